// ===== rtl/hbf_pkg.sv =====
// Shared types and constants of the Hessian box-filter response block.
package hbf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FILTER_SIZE  = 3'd0;
  localparam logic [2:0] REG_SAMPLE_STEP  = 3'd1;
  localparam logic [2:0] REG_AREA_RECIP   = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

  // Input item kinds carried on tuser.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Reset values of the configuration registers and their derived terms.
  localparam logic [8:0] FILTER_SIZE_RST  = 9'd9;
  localparam logic [7:0] SAMPLE_STEP_RST  = 8'd2;
  localparam logic [9:0] AREA_RECIP_RST   = 10'd809;
  localparam logic [9:0] IMAGE_WIDTH_RST  = 10'd512;
  localparam logic [9:0] IMAGE_HEIGHT_RST = 10'd512;
  localparam logic [7:0] LOBE_RST         = 8'd3;
  localparam logic [8:0] BORDER_RST       = 9'd5;

  // Division by three of a 9-bit size as a multiply by 171 and a shift by 9.
  localparam logic [7:0] RECIP3_Q9 = 8'd171;

  // 0.81 in Q16.
  localparam logic [15:0] COEF_081_Q16 = 16'd53084;

  // Signed coordinate width, wide enough for sample position times step plus a filter.
  localparam int COORD_W = 20;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Normalized term limit and response width.
  localparam logic signed [31:0] NORM_MAX = 32'sh7FFF_FFFF;
  localparam int RESP_W = 41;

  // Field widths.
  localparam int ADDR_W  = 18;
  localparam int DATA_W  = 32;
  localparam int SAMP_W  = 9;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 48;

endpackage

// ===== rtl/hbf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module hbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hessian_box_filter_response_top.sv =====
// Top level: integral image store and the box-filter Hessian determinant sequencer.
//
//  Channel   Direction  Transfer when          Content
//  s_*       in         s_tvalid & s_tready    tuser: opcode; tdata: address, data, row, col
//  m_*       out        m_tvalid & m_tready    tdata: response (41-bit signed)
//  cfg_*     in         cfg_write              cfg_index selects register, cfg_data value
//
// A write item leaves the block idle. A compute item keeps the block busy from its transfer until
// it is ready again: 32 corner reads through the single read port of the integral image
// RAM, then a drain state, the normalize states NXX, NYY and NXY, the product states PQ and
// SQ, a scaling state and the DONE state that loads the output register.
// The output register holds a result while the next item is accepted; a stalled
// output only holds the block when a new result is ready to be loaded.
// rst is synchronous and restores the register reset values; the RAM is not cleared.
module hessian_box_filter_response_top
  import hbf_pkg::*;
#(
  parameter int MAX_IMAGE_WIDTH  = 512,
  parameter int MAX_IMAGE_HEIGHT = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // address[17:0], data[49:18], sample_row[58:50],
                                          // sample_col[67:59], zero fill
  input  logic                 s_tuser,   // opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // response[40:0], zero fill
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [9:0]           cfg_data
);

  localparam int DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DRAIN, ST_NXX, ST_NYY, ST_NXY, ST_PQ, ST_SQ, ST_SCALE, ST_DONE
  } state_t;

  // Configuration registers.
  logic [8:0] filter_size;
  logic [7:0] sample_step;
  logic [9:0] area_recip;
  logic [9:0] image_width;
  logic [9:0] image_height;
  logic [7:0] lobe;
  logic [8:0] border;
  logic [16:0] lobe_prod;

  assign lobe_prod = cfg_data[8:0] * RECIP3_Q9;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_size  <= FILTER_SIZE_RST;
      sample_step  <= SAMPLE_STEP_RST;
      area_recip   <= AREA_RECIP_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      lobe         <= LOBE_RST;
      border       <= BORDER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_SIZE: begin
          filter_size <= cfg_data[8:0];
          lobe        <= lobe_prod[16:9];
          border      <= (cfg_data[8:0] == 9'd0) ? 9'd1 :
                         9'((cfg_data[8:0] - 9'd1) >> 1) + 9'd1;
        end
        REG_SAMPLE_STEP:  sample_step  <= cfg_data[7:0];
        REG_AREA_RECIP:   area_recip   <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_data;
  logic [SAMP_W-1:0] in_row;
  logic [SAMP_W-1:0] in_col;
  logic              in_xfer;

  assign in_address = s_tdata[17:0];
  assign in_data    = s_tdata[49:18];
  assign in_row     = s_tdata[58:50];
  assign in_col     = s_tdata[67:59];

  state_t state;
  logic [4:0] cnt;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // Image position of the sample.
  coord_t pos_r;
  coord_t pos_c;

  // Box geometry for the current corner's box.
  coord_t l_s, l2m1, lh, b_s, w_s;
  coord_t box_r, box_nr, box_c, box_nc;

  assign l_s  = coord_t'(lobe);
  assign l2m1 = coord_t'({lobe, 1'b0}) - coord_t'(1);
  assign lh   = coord_t'(lobe >> 1);
  assign b_s  = coord_t'(border);
  assign w_s  = coord_t'(filter_size);

  always_comb begin
    unique case (cnt[4:2])
      3'd0: begin
        box_r = pos_r - l_s + coord_t'(1); box_nr = l2m1; box_c = pos_c - b_s; box_nc = w_s;
      end
      3'd1: begin
        box_r = pos_r - l_s + coord_t'(1); box_nr = l2m1; box_c = pos_c - lh; box_nc = l_s;
      end
      3'd2: begin
        box_r = pos_r - b_s; box_nr = w_s; box_c = pos_c - l_s + coord_t'(1); box_nc = l2m1;
      end
      3'd3: begin
        box_r = pos_r - lh; box_nr = l_s; box_c = pos_c - l_s + coord_t'(1); box_nc = l2m1;
      end
      3'd4: begin
        box_r = pos_r - l_s; box_nr = l_s; box_c = pos_c + coord_t'(1); box_nc = l_s;
      end
      3'd5: begin
        box_r = pos_r + coord_t'(1); box_nr = l_s; box_c = pos_c - l_s; box_nc = l_s;
      end
      3'd6: begin
        box_r = pos_r - l_s; box_nr = l_s; box_c = pos_c - l_s; box_nc = l_s;
      end
      default: begin
        box_r = pos_r + coord_t'(1); box_nr = l_s; box_c = pos_c + coord_t'(1); box_nc = l_s;
      end
    endcase
  end

  // Corner position, clipped to the image; corners 0..3 are A, B, C, D.
  coord_t h_cap, w_cap, edge_r, edge_c, clip_r, clip_c;
  logic   corner_zero;
  logic [AW-1:0] rd_addr;

  assign h_cap  = (coord_t'(image_height) > coord_t'(MAX_IMAGE_HEIGHT)) ?
                  coord_t'(MAX_IMAGE_HEIGHT) : coord_t'(image_height);
  assign w_cap  = (coord_t'(image_width) > coord_t'(MAX_IMAGE_WIDTH)) ?
                  coord_t'(MAX_IMAGE_WIDTH) : coord_t'(image_width);
  assign edge_r = cnt[1] ? box_r + box_nr : box_r;
  assign edge_c = cnt[0] ? box_c + box_nc : box_c;
  assign clip_r = ((edge_r < h_cap) ? edge_r : h_cap) - coord_t'(1);
  assign clip_c = ((edge_c < w_cap) ? edge_c : w_cap) - coord_t'(1);
  assign corner_zero = clip_r[COORD_W-1] || clip_c[COORD_W-1];
  assign rd_addr = AW'(unsigned'(clip_r)) * AW'(MAX_IMAGE_WIDTH) + AW'(unsigned'(clip_c));

  // Integral image store.
  logic              wr_en;
  logic [DATA_W-1:0] rd_data;

  assign wr_en = in_xfer && (s_tuser == OP_WRITE) && (32'(in_address) < 32'(DEPTH));

  hbf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_address)),
    .wdata (in_data),
    .re    (state == ST_READ),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Returned corner data, signed by its place in the box.
  logic        rd_valid;
  logic [4:0]  rd_k;
  logic        rd_zero;
  logic signed [34:0] term, sterm, box_acc, box_sum, box_clamp;

  assign term      = rd_zero ? 35'sd0 : $signed({3'b000, rd_data});
  assign sterm     = (rd_k[1] ^ rd_k[0]) ? -term : term;
  assign box_sum   = box_acc + sterm;
  assign box_clamp = box_sum[34] ? 35'sd0 : box_sum;

  logic signed [37:0] dxx, dyy, dxy, box_ext, box_x3;

  assign box_ext = 38'(box_clamp);
  assign box_x3  = (box_ext <<< 1) + box_ext;

  // Normalize: one shared multiply by the inverse area.
  logic signed [37:0] norm_d;
  logic signed [48:0] norm_prod;
  logic signed [31:0] norm_sat;
  logic signed [31:0] nxx, nyy, nxy;

  always_comb begin
    priority case (state)
      ST_NXX:  norm_d = dxx;
      ST_NYY:  norm_d = dyy;
      default: norm_d = dxy;
    endcase
  end

  assign norm_prod = norm_d * $signed({1'b0, area_recip});
  assign norm_sat  = (norm_prod > 49'(NORM_MAX)) ? NORM_MAX :
                     (norm_prod < -49'(NORM_MAX)) ? -NORM_MAX : norm_prod[31:0];

  // Products, 0.81 scaling and final shift.
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_out, p_prod;
  logic [63:0] q_prod, m_hi, m_sum;
  logic [15:0] m_lo;
  logic [31:0] m_lo_full;
  logic signed [63:0] diff;
  logic signed [47:0] shifted;
  logic signed [RESP_W-1:0] resp;

  assign mul_b     = (state == ST_PQ) ? nyy : nxy;
  assign mul_out   = ((state == ST_PQ) ? nxx : nxy) * mul_b;
  assign m_lo_full = q_prod[15:0] * COEF_081_Q16;
  assign m_sum     = m_hi + 64'(m_lo);
  assign diff      = p_prod - $signed(m_sum);
  assign shifted   = 48'(diff >>> 16);
  assign resp      = (shifted > 48'sh00FF_FFFF_FFFF) ? {1'b0, {(RESP_W-1){1'b1}}} :
                     (shifted < -48'sh0100_0000_0000) ? {1'b1, {(RESP_W-1){1'b0}}} :
                     shifted[RESP_W-1:0];

  // Sequencer, accumulators and output register.
  logic [RESP_W-1:0] out_resp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A new result takes the output register; otherwise a transfer empties it.
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= (state == ST_READ);
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (s_tuser == OP_COMPUTE)) begin
            cnt   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_NXX;
        ST_NXX:   state <= ST_NYY;
        ST_NYY:   state <= ST_NXY;
        ST_NXY:   state <= ST_PQ;
        ST_PQ:    state <= ST_SQ;
        ST_SQ:    state <= ST_SCALE;
        ST_SCALE: state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_k    <= cnt;
    rd_zero <= corner_zero;
    if (in_xfer && (s_tuser == OP_COMPUTE)) begin
      pos_r <= coord_t'(in_row * sample_step);
      pos_c <= coord_t'(in_col * sample_step);
      dxx   <= '0;
      dyy   <= '0;
      dxy   <= '0;
    end
    // Four corners build one box; the last corner folds it into its derivative.
    if (rd_valid) begin
      box_acc <= (rd_k[1:0] == 2'd0) ? sterm : box_sum;
      if (rd_k[1:0] == 2'd3) begin
        unique case (rd_k[4:2])
          3'd0:       dxx <= dxx + box_ext;
          3'd1:       dxx <= dxx - box_x3;
          3'd2:       dyy <= dyy + box_ext;
          3'd3:       dyy <= dyy - box_x3;
          3'd4, 3'd5: dxy <= dxy + box_ext;
          default:    dxy <= dxy - box_ext;
        endcase
      end
    end
    if (state == ST_NXX) nxx <= norm_sat;
    if (state == ST_NYY) nyy <= norm_sat;
    if (state == ST_NXY) nxy <= norm_sat;
    if (state == ST_PQ)  p_prod <= mul_out;
    if (state == ST_SQ)  q_prod <= unsigned'(mul_out);
    if (state == ST_SCALE) begin
      m_hi <= 64'(q_prod[63:16] * COEF_081_Q16);
      m_lo <= m_lo_full[31:16];
    end
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      out_resp <= resp;
    end
  end

  assign m_tdata = {(M_TDATA_W-RESP_W)'(0), out_resp};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Hessian box-filter response block.
`timescale 1ns / 1ps

module testbench;
  import hbf_pkg::*;

  localparam int STORE_COLS = 512;
  localparam int STORE_ROWS = 512;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [SAMP_W-1:0] sample_row;
    logic [SAMP_W-1:0] sample_col;
  } hbf_item_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = OP_WRITE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_write;
  logic [2:0]           cfg_index;
  logic [9:0]           cfg_data;

  // Items waiting to be offered, and responses still owed by the block.
  hbf_item_t               pending_items[$];
  logic signed [RESP_W-1:0] expected_resp[$];

  // Predictor state: integral image copy and current register values.
  logic [31:0] image_mem [0:STORE_ROWS*STORE_COLS-1];
  bit          word_written [0:STORE_ROWS*STORE_COLS-1];
  int          cur_size, cur_step, cur_inv, cur_width, cur_height;

  int  errors = 0;
  int  cycles = 0;
  bit  idle_on;
  bit  stall_req;
  bit  stall_done = 1'b0;
  bit  in_fire = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  hessian_box_filter_response_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Clipped box sum over the stored integral image, clamped at zero.
  function automatic longint box_sum(int row, int col, int nr, int nc);
    int h, w, r1, c1, r2, c2;
    longint a, b, c, d, s;
    h = (cur_height < STORE_ROWS) ? cur_height : STORE_ROWS;
    w = (cur_width < STORE_COLS) ? cur_width : STORE_COLS;
    r1 = ((row < h) ? row : h) - 1;
    c1 = ((col < w) ? col : w) - 1;
    r2 = ((row + nr < h) ? row + nr : h) - 1;
    c2 = ((col + nc < w) ? col + nc : w) - 1;
    a = (r1 >= 0 && c1 >= 0) ? longint'(image_mem[r1*STORE_COLS+c1]) : 0;
    b = (r1 >= 0 && c2 >= 0) ? longint'(image_mem[r1*STORE_COLS+c2]) : 0;
    c = (r2 >= 0 && c1 >= 0) ? longint'(image_mem[r2*STORE_COLS+c1]) : 0;
    d = (r2 >= 0 && c2 >= 0) ? longint'(image_mem[r2*STORE_COLS+c2]) : 0;
    s = a - b - c + d;
    return (s < 0) ? 0 : s;
  endfunction

  // Scale a derivative by the Q16 inverse area and saturate to 31 bits.
  function automatic longint scale_term(longint d);
    longint n;
    n = d * longint'(cur_inv);
    if (n > 64'sd2147483647) n = 64'sd2147483647;
    if (n < -64'sd2147483647) n = -64'sd2147483647;
    return n;
  endfunction

  // Determinant of the Hessian approximation at a sample position.
  function automatic logic signed [RESP_W-1:0] hessian_det(int srow, int scol);
    int r, c, w, l, b;
    longint dxx, dyy, dxy, nxx, nyy, nxy, p, v;
    logic [63:0] q, m;
    r = srow * cur_step;
    c = scol * cur_step;
    w = cur_size;
    l = w / 3;
    b = (w - 1) / 2 + 1;
    dxx = box_sum(r - l + 1, c - b, 2 * l - 1, w)
        - 3 * box_sum(r - l + 1, c - l / 2, 2 * l - 1, l);
    dyy = box_sum(r - b, c - l + 1, w, 2 * l - 1)
        - 3 * box_sum(r - l / 2, c - l + 1, l, 2 * l - 1);
    dxy = box_sum(r - l, c + 1, l, l) + box_sum(r + 1, c - l, l, l)
        - box_sum(r - l, c - l, l, l) - box_sum(r + 1, c + 1, l, l);
    nxx = scale_term(dxx);
    nyy = scale_term(dyy);
    nxy = scale_term(dxy);
    p = nxx * nyy;
    q = nxy * nxy;
    m = (q >> 16) * COEF_081_Q16 + (((q & 64'hFFFF) * COEF_081_Q16) >> 16);
    v = (p - longint'(m)) >>> 16;
    if (v > 64'sd1099511627775) v = 64'sd1099511627775;
    if (v < -64'sd1099511627776) v = -64'sd1099511627776;
    return v[RESP_W-1:0];
  endfunction

  // Input driver: holds an item until its transfer, then pops the next one.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
      s_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap = in_gap - 1;
      s_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      hbf_item_t it;
      it = pending_items.pop_front();
      s_tuser <= it.opcode;
      s_tdata <= {4'b0, it.sample_col, it.sample_row, it.data, it.address};
      s_tvalid <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 18);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Output receiver: random stalls plus one long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done = 1'b1;
      out_gap = 800;
      m_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      cycles = cycles + 1;
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_WRITE)
          image_mem[s_tdata[ADDR_W-1:0]] = s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        else
          expected_resp = {expected_resp,
                           hessian_det(int'(s_tdata[58:50]), int'(s_tdata[67:59]))};
      end
      if (m_tvalid && m_tready) begin
        if (expected_resp.size() == 0) begin
          $error("unexpected response transfer: %0d", $signed(m_tdata[RESP_W-1:0]));
          errors = errors + 1;
        end else begin
          logic signed [RESP_W-1:0] want;
          want = expected_resp.pop_front();
          if (m_tdata[RESP_W-1:0] !== want) begin
            $error("response: expected %0d, actual %0d", want,
                   $signed(m_tdata[RESP_W-1:0]));
            errors = errors + 1;
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Waits until every item is accepted and every response has arrived.
  task automatic wait_drained();
    while (pending_items.size() > 0 || s_tvalid || expected_resp.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[9:0];
    case (idx)
      REG_FILTER_SIZE:  cur_size   = value & 32'h1FF;
      REG_SAMPLE_STEP:  cur_step   = value & 32'hFF;
      REG_AREA_RECIP:   cur_inv    = value & 32'h3FF;
      REG_IMAGE_WIDTH:  cur_width  = value & 32'h3FF;
      REG_IMAGE_HEIGHT: cur_height = value & 32'h3FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_write(int addr, logic [31:0] value);
    hbf_item_t it;
    it.opcode = OP_WRITE;
    it.address = addr[ADDR_W-1:0];
    it.data = value;
    it.sample_row = SAMP_W'($urandom);
    it.sample_col = SAMP_W'($urandom);
    word_written[addr] = 1'b1;
    pending_items = {pending_items, it};
  endtask

  task automatic push_compute(int srow, int scol);
    hbf_item_t it;
    it.opcode = OP_COMPUTE;
    it.address = ADDR_W'($urandom);
    it.data = $urandom;
    it.sample_row = srow[SAMP_W-1:0];
    it.sample_col = scol[SAMP_W-1:0];
    pending_items = {pending_items, it};
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // One setting: configure, fill the clipped image area, then random traffic.
  task automatic run_setting(int fsize, int step, int inv, int w, int h, int n);
    int rows, cols, srow, scol, lim;
    wait_drained();
    write_reg(REG_FILTER_SIZE, fsize);
    write_reg(REG_SAMPLE_STEP, step);
    write_reg(REG_AREA_RECIP, inv);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    rows = (h < STORE_ROWS) ? h : STORE_ROWS;
    cols = (w < STORE_COLS) ? w : STORE_COLS;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!word_written[r*STORE_COLS+c]) push_write(r*STORE_COLS + c, pick_data());
    // Corners of the sample space.
    push_compute(0, 0);
    push_compute(511, 511);
    push_compute(0, 511);
    push_compute(511, 0);
    lim = (step > 0) ? (((rows > cols) ? rows : cols) / step + 2) : 511;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if (rows > 0 && cols > 0 && $urandom_range(0, 2) != 0)
          push_write($urandom_range(0, rows-1) * STORE_COLS + $urandom_range(0, cols-1),
                     pick_data());
        else
          push_write($urandom_range(0, STORE_ROWS*STORE_COLS-1), pick_data());
      end else begin
        srow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, lim);
        scol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, lim);
        push_compute(srow, scol);
      end
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    idle_on = 1'b1;
    stall_req = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_FILTER_SIZE;
    cfg_data = '0;
    cur_size = FILTER_SIZE_RST;
    cur_step = SAMPLE_STEP_RST;
    cur_inv = AREA_RECIP_RST;
    cur_width = IMAGE_WIDTH_RST;
    cur_height = IMAGE_HEIGHT_RST;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Highest address of the store, written once.
    push_write(STORE_ROWS*STORE_COLS - 1, 32'hFFFF_FFFF);
    run_setting(9, 2, 809, 10, 10, 40);
    // Long receiver hold-off while the sender keeps offering.
    stall_req = 1'b1;
    run_setting(387, 128, 1, 14, 10, 35);
    run_setting(3, 1, 1023, 1, 16, 30);
    run_setting(511, 255, 809, 1023, 0, 20);
    run_setting(15, 1, 291, 12, 12, 35);
    run_setting(0, 0, 0, 0, 0, 15);
    run_setting(27, 3, 90, 14, 14, 35);
    // Final stretch without idling.
    wait_drained();
    idle_on = 1'b0;
    run_setting(9, 1, 809, 12, 12, 30);
    wait_drained();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
